// ===== hdl/llp_pkg.sv =====
// ----------------------------------------------------------------------------
// llp_pkg
// Shared types and constants of the LL(1) predictive parse engine.
// ----------------------------------------------------------------------------
package llp_pkg;

  localparam logic [7:0] END_MARK  = 8'h24;  // '$'
  localparam logic [7:0] UPPER_LO  = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_HI  = 8'h5A;  // 'Z'
  localparam int         ROWS      = 26;
  localparam int         COLS      = 256;
  localparam int         TBL_DEPTH = ROWS * COLS;
  localparam int         TBL_AW    = 13;
  localparam int         CELL_W    = 6;

  typedef enum logic [1:0] {
    ACT_PROD  = 2'd0,
    ACT_CELL  = 2'd1,
    ACT_START = 2'd2,
    ACT_TOKEN = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_MATCHED  = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NORULE   = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_LIMIT    = 3'd5,
    ST_IDLE     = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_READ_TOP,
    S_CHECK_TOP,
    S_LOOKUP,
    S_PROD,
    S_PUSH,
    S_RESULT
  } state_t;

endpackage

// ===== hdl/ll1_table_driven_parser_top.sv =====
// ----------------------------------------------------------------------------
// ll1_table_driven_parser_top
// LL(1) table-driven predictive parse engine with loadable grammar.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ channel; s_tuser carries the action (write
// production, write table cell, start parse, token). Only token requests
// produce a result, which leaves on the m_ channel. The start symbol is
// written through the cfg_ channel; the user must write it only while the
// engine is idle, since the block itself does not enforce this.
// After reset the engine sweeps the parse table to clear every cell, and
// s_tready stays low during the sweep. A start writes the end marker and
// the start symbol into the stack RAM one after the other. A token walks
// a small sequencer around one stack RAM port: read top, table lookup,
// production fetch, then one push per symbol plus a step to close the
// expansion, repeated per expansion; the final read and compare and the
// result state follow.
// The result sits in an output register, so the engine keeps taking requests
// while one result waits. If the receiver stalls, the next token holds the
// engine in its result state and no new request is taken until the output
// register is free.
// ----------------------------------------------------------------------------
module ll1_table_driven_parser_top
  import llp_pkg::*;
#(
  parameter int STACK_DEPTH     = 64,
  parameter int NUM_PRODUCTIONS = 32,
  parameter int MAX_RHS         = 8,
  parameter int MAX_EXPANSIONS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: prod_index[4:0], rhs_length[8:5], rhs_symbols[72:9],
  //   cell_nonterminal[77:73], cell_terminal[85:78], cell_valid[86],
  //   token[94:87], zero[95]
  input  logic [95:0] s_tdata,
  // s_tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[2:0], failing_top[10:3], expansions[17:11], zero[23:18]
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int PAW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int EW  = $clog2(MAX_EXPANSIONS + 1);

  // Request fields.
  logic [4:0]  in_prod_index;
  logic [3:0]  in_rhs_length;
  logic [63:0] in_rhs_symbols;
  logic [4:0]  in_cell_nt;
  logic [7:0]  in_cell_term;
  logic        in_cell_valid;
  logic [7:0]  in_token;
  action_t     in_action;

  assign in_prod_index  = s_tdata[4:0];
  assign in_rhs_length  = s_tdata[8:5];
  assign in_rhs_symbols = s_tdata[72:9];
  assign in_cell_nt     = s_tdata[77:73];
  assign in_cell_term   = s_tdata[85:78];
  assign in_cell_valid  = s_tdata[86];
  assign in_token       = s_tdata[94:87];
  assign in_action      = action_t'(s_tuser);

  logic accept;
  assign accept = s_tvalid && s_tready;

  // Control and working registers.
  state_t          state, state_next;
  logic [6:0]      start_symbol;
  logic [SCW-1:0]  stack_count, stack_count_next;
  logic            parsing, parsing_next;
  logic [7:0]      tok, tok_next;
  logic [7:0]      top, top_next;
  logic [EW-1:0]   exps, exps_next;
  logic [3:0]      push_cnt, push_cnt_next;
  logic [63:0]     push_syms, push_syms_next;
  logic [TBL_AW-1:0] clr_addr, clr_addr_next;
  status_t         res_status, res_status_next;
  logic [7:0]      res_top, res_top_next;
  logic [6:0]      res_exps, res_exps_next;
  logic            out_valid, out_valid_next;
  logic [17:0]     out_data, out_data_next;

  // Memory ports.
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [CELL_W-1:0] tbl_wdata, tbl_rdata;
  logic              prd_we;
  logic [PAW-1:0]    prd_waddr, prd_raddr;
  logic [67:0]       prd_wdata, prd_rdata;

  llp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
    .rd_addr(stk_raddr), .rd_data(stk_rdata)
  );

  llp_ram #(.WIDTH(CELL_W), .DEPTH(TBL_DEPTH), .AW(TBL_AW)) u_table (
    .clk(clk), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
    .rd_addr(tbl_raddr), .rd_data(tbl_rdata)
  );

  llp_ram #(.WIDTH(68), .DEPTH(NUM_PRODUCTIONS), .AW(PAW)) u_prod (
    .clk(clk), .wr_en(prd_we), .wr_addr(prd_waddr), .wr_data(prd_wdata),
    .rd_addr(prd_raddr), .rd_data(prd_rdata)
  );

  // Helper values.
  logic [SCW-1:0] count_m1;
  logic [12:0]    pidx_ext, cellp_ext;
  logic [4:0]     row_of_top;
  logic [3:0]     prd_len;
  logic [SCW:0]   need;
  logic [3:0]     push_m1;
  logic [EW+6:0]  exps_ext;
  logic [EW-1:0]  exps_inc;

  assign count_m1   = stack_count - SCW'(1);
  assign pidx_ext   = {8'd0, in_prod_index};
  assign cellp_ext  = {8'd0, tbl_rdata[4:0]};
  assign row_of_top = 5'(stk_rdata - UPPER_LO);
  assign prd_len    = prd_rdata[67:64];
  assign need       = {1'b0, count_m1} + (SCW + 1)'(prd_len);
  assign push_m1    = push_cnt - 4'd1;
  assign exps_inc   = exps + EW'(1);
  assign exps_ext   = {7'd0, exps};

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'd0, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol <= 7'd83;
    end else if (cfg_valid && cfg_ready) begin
      start_symbol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      stack_count <= '0;
      parsing     <= 1'b0;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      parsing     <= parsing_next;
      clr_addr    <= clr_addr_next;
      out_valid   <= out_valid_next;
    end
    tok        <= tok_next;
    top        <= top_next;
    exps       <= exps_next;
    push_cnt   <= push_cnt_next;
    push_syms  <= push_syms_next;
    res_status <= res_status_next;
    res_top    <= res_top_next;
    res_exps   <= res_exps_next;
    out_data   <= out_data_next;
  end

  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    parsing_next     = parsing;
    tok_next         = tok;
    top_next         = top;
    exps_next        = exps;
    push_cnt_next    = push_cnt;
    push_syms_next   = push_syms;
    clr_addr_next    = clr_addr;
    res_status_next  = res_status;
    res_top_next     = res_top;
    res_exps_next    = res_exps;
    out_valid_next   = out_valid;
    out_data_next    = out_data;

    stk_we    = 1'b0;
    stk_waddr = stack_count[SAW-1:0];
    stk_wdata = END_MARK;
    stk_raddr = count_m1[SAW-1:0];
    tbl_we    = 1'b0;
    tbl_waddr = {in_cell_nt, in_cell_term};
    tbl_wdata = in_cell_valid ? {1'b1, in_prod_index} : '0;
    tbl_raddr = {row_of_top, tok};
    prd_we    = 1'b0;
    prd_waddr = pidx_ext[PAW-1:0];
    prd_wdata = {(in_rhs_length > 4'(MAX_RHS)) ? 4'(MAX_RHS) : in_rhs_length,
                 in_rhs_symbols};
    prd_raddr = cellp_ext[PAW-1:0];

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_addr;
        tbl_wdata = '0;
        clr_addr_next = clr_addr + TBL_AW'(1);
        if (clr_addr == TBL_AW'(TBL_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PROD: begin
              prd_we = (32'(in_prod_index) < NUM_PRODUCTIONS);
            end
            ACT_CELL: begin
              tbl_we = (32'(in_cell_nt) < ROWS);
            end
            ACT_START: begin
              stk_we     = 1'b1;
              stk_waddr  = '0;
              stk_wdata  = END_MARK;
              state_next = S_START;
            end
            ACT_TOKEN: begin
              tok_next  = in_token;
              exps_next = '0;
              if (parsing) begin
                state_next = S_READ_TOP;
              end else begin
                res_status_next = ST_IDLE;
                res_top_next    = 8'd0;
                res_exps_next   = 7'd0;
                state_next      = S_RESULT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        stk_we           = 1'b1;
        stk_waddr        = SAW'(1);
        stk_wdata        = {1'b0, start_symbol};
        stack_count_next = SCW'(2);
        parsing_next     = 1'b1;
        state_next       = S_IDLE;
      end
      S_READ_TOP: begin
        // Stack read address is count - 1; data is valid next cycle.
        if (stack_count == '0) begin
          parsing_next    = 1'b0;
          res_status_next = ST_IDLE;
          res_top_next    = 8'd0;
          res_exps_next   = 7'd0;
          state_next      = S_RESULT;
        end else begin
          state_next = S_CHECK_TOP;
        end
      end
      S_CHECK_TOP: begin
        top_next = stk_rdata;
        if (stk_rdata >= UPPER_LO && stk_rdata <= UPPER_HI) begin
          state_next = S_LOOKUP;
        end else if (stk_rdata != tok) begin
          parsing_next    = 1'b0;
          res_status_next = ST_MISMATCH;
          res_top_next    = stk_rdata;
          res_exps_next   = exps_ext[6:0];
          state_next      = S_RESULT;
        end else begin
          stack_count_next = count_m1;
          res_top_next     = 8'd0;
          res_exps_next    = exps_ext[6:0];
          if (count_m1 == '0) begin
            parsing_next    = 1'b0;
            res_status_next = ST_ACCEPTED;
          end else begin
            res_status_next = ST_MATCHED;
          end
          state_next = S_RESULT;
        end
      end
      S_LOOKUP: begin
        res_top_next  = top;
        res_exps_next = exps_ext[6:0];
        if (!tbl_rdata[5] || 32'(tbl_rdata[4:0]) >= NUM_PRODUCTIONS) begin
          parsing_next    = 1'b0;
          res_status_next = ST_NORULE;
          state_next      = S_RESULT;
        end else if (32'(exps) >= MAX_EXPANSIONS) begin
          parsing_next    = 1'b0;
          res_status_next = ST_LIMIT;
          state_next      = S_RESULT;
        end else begin
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        if (32'(need) > STACK_DEPTH) begin
          parsing_next    = 1'b0;
          res_status_next = ST_OVERFLOW;
          state_next      = S_RESULT;
        end else begin
          stack_count_next = count_m1;
          push_cnt_next    = prd_len;
          push_syms_next   = prd_rdata[63:0];
          state_next       = S_PUSH;
        end
      end
      S_PUSH: begin
        // Symbols go in last first, so the first symbol ends on top.
        if (push_cnt == 4'd0) begin
          exps_next  = exps_inc;
          state_next = S_READ_TOP;
        end else begin
          stk_we           = 1'b1;
          stk_wdata        = push_syms[8*push_m1[2:0] +: 8];
          stack_count_next = stack_count + SCW'(1);
          push_cnt_next    = push_m1;
        end
      end
      S_RESULT: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {res_exps, res_top, res_status};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(stack_count) <= STACK_DEPTH)
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && push_cnt != 4'd0) |-> 32'(stack_count) < STACK_DEPTH)
    else $error("push without room");

  a_ok_top_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == ST_MATCHED || m_tdata[2:0] == ST_ACCEPTED))
      |-> m_tdata[10:3] == 8'd0)
    else $error("failing top set on success");

  a_not_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_TOKEN) |=> !s_tready)
    else $error("ready while token in work");
`endif

endmodule

// ===== hdl/llp_ram.sv =====
// ----------------------------------------------------------------------------
// llp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module llp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
